// ===== rtl/core/wrhp_pkg.sv =====
package wrhp_pkg;

    typedef enum logic [2:0] {
        PH_SIG_RIFF   = 3'd0,
        PH_RIFF_SIZE  = 3'd1,
        PH_SIG_WAVE   = 3'd2,
        PH_CHUNK_ID   = 3'd3,
        PH_CHUNK_SIZE = 3'd4,
        PH_FMT_BODY   = 3'd5,
        PH_SKIP       = 3'd6,
        PH_DONE       = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_END     = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SIG = 2'd1,
        ST_NOT_PCM = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM      = 16'd1;

    // byte index within a phase: signatures and sizes use 0..3, fmt body 0..15
    localparam int unsigned CNT_W = 4;

endpackage

// ===== rtl/core/wav_riff_header_parser.sv =====
// RIFF/WAVE header parser. Feed the file one byte per transfer with action 0,
// signal end of stream with action 1 and start over with action 2. The block
// checks the RIFF and WAVE signatures, walks the chunks, takes format, channels,
// sample rate and bits per sample from the fmt chunk and the size of the data
// chunk, and delivers at most one result per parse: when both chunks are found,
// on a bad signature or non-PCM format, or at end of stream. After a result,
// further bytes and end of stream are ignored until a restart. Throughput is
// one byte per clock: each byte passes an input register and a single decode
// step that updates the parse state and loads the result register, from which
// a result is presented once its transfer has passed the input register. The
// input side stalls only while a result is held by a stalled output.
module wav_riff_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_stream_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_rate_hz,
    output logic [15:0] o_channel_count,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_payload_size
);
    import wrhp_pkg::*;

    // input register
    logic             r_in_valid;
    logic [1:0]       r_action;
    logic [7:0]       r_byte;

    // parse state
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_id, n_id;
    logic [31:0]      r_len, n_len;
    logic             r_fmt_seen, n_fmt_seen;
    logic             r_data_seen, n_data_seen;
    logic [15:0]      r_format_tag, n_format_tag;
    logic [31:0]      r_rate, n_rate;
    logic [15:0]      r_channels, n_channels;
    logic [15:0]      r_bits, n_bits;
    logic [31:0]      r_payload_len, n_payload_len;

    // result register
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [31:0]      r_out_rate;
    logic [15:0]      r_out_channels;
    logic [15:0]      r_out_bits;
    logic [31:0]      r_out_size;

    logic             can_proc;
    logic             proc;
    logic             load_in;
    logic             emit;
    t_status          emit_status;
    logic [31:0]      fmt_rest;

    assign can_proc   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && can_proc;
    assign load_in    = !r_in_valid || can_proc;
    assign o_in_stall = !load_in;

    assign fmt_rest = (r_len > FMT_BODY_LEN) ? (r_len - FMT_BODY_LEN) : 32'd0;

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_id          = r_id;
        n_len         = r_len;
        n_fmt_seen    = r_fmt_seen;
        n_data_seen   = r_data_seen;
        n_format_tag  = r_format_tag;
        n_rate        = r_rate;
        n_channels    = r_channels;
        n_bits        = r_bits;
        n_payload_len = r_payload_len;
        emit          = 1'b0;
        emit_status   = ST_OK;

        if (proc) begin
            case (t_action'(r_action))
                ACT_RESTART: begin
                    n_phase       = PH_SIG_RIFF;
                    n_count       = '0;
                    n_id          = '0;
                    n_len         = '0;
                    n_fmt_seen    = 1'b0;
                    n_data_seen   = 1'b0;
                    n_format_tag  = '0;
                    n_rate        = '0;
                    n_channels    = '0;
                    n_bits        = '0;
                    n_payload_len = '0;
                end
                ACT_END: begin
                    case (r_phase)
                        PH_SIG_RIFF, PH_RIFF_SIZE, PH_SIG_WAVE: begin
                            emit        = 1'b1;
                            emit_status = ST_BAD_SIG;
                        end
                        PH_DONE: ;
                        default: begin
                            emit        = 1'b1;
                            emit_status = ST_MISSING;
                        end
                    endcase
                end
                ACT_BYTE: begin
                    n_count = r_count + 1'b1;
                    unique case (r_phase)
                        PH_SIG_RIFF, PH_SIG_WAVE: begin
                            n_id = {r_id[23:0], r_byte};
                            if (r_count == CNT_W'(3)) begin
                                if (n_id != ((r_phase == PH_SIG_RIFF) ? ID_RIFF : ID_WAVE)) begin
                                    emit        = 1'b1;
                                    emit_status = ST_BAD_SIG;
                                end else begin
                                    n_count = '0;
                                    n_phase = (r_phase == PH_SIG_RIFF) ? PH_RIFF_SIZE
                                                                       : PH_CHUNK_ID;
                                end
                            end
                        end
                        PH_RIFF_SIZE: begin
                            if (r_count == CNT_W'(3)) begin
                                n_count = '0;
                                n_phase = PH_SIG_WAVE;
                            end
                        end
                        PH_CHUNK_ID: begin
                            n_id = {r_id[23:0], r_byte};
                            if (r_count == CNT_W'(3)) begin
                                n_count = '0;
                                n_len   = '0;
                                n_phase = PH_CHUNK_SIZE;
                            end
                        end
                        PH_CHUNK_SIZE: begin
                            // size is little-endian
                            case (r_count[1:0])
                                2'd0:    n_len[7:0]   = r_byte;
                                2'd1:    n_len[15:8]  = r_byte;
                                2'd2:    n_len[23:16] = r_byte;
                                default: n_len[31:24] = r_byte;
                            endcase
                            if (r_count == CNT_W'(3)) begin
                                n_count = '0;
                                if (r_id == ID_FMT) begin
                                    n_phase = PH_FMT_BODY;
                                end else begin
                                    if (r_id == ID_DATA) begin
                                        n_payload_len = n_len;
                                        n_data_seen   = 1'b1;
                                    end
                                    if (r_id == ID_DATA && r_fmt_seen) begin
                                        emit = 1'b1;
                                    end else begin
                                        n_phase = (n_len == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
                                    end
                                end
                            end
                        end
                        PH_FMT_BODY: begin
                            case (r_count)
                                4'd0:    n_format_tag[7:0]  = r_byte;
                                4'd1:    n_format_tag[15:8] = r_byte;
                                4'd2:    n_channels[7:0]    = r_byte;
                                4'd3:    n_channels[15:8]   = r_byte;
                                4'd4:    n_rate[7:0]        = r_byte;
                                4'd5:    n_rate[15:8]       = r_byte;
                                4'd6:    n_rate[23:16]      = r_byte;
                                4'd7:    n_rate[31:24]      = r_byte;
                                4'd14:   n_bits[7:0]        = r_byte;
                                4'd15:   n_bits[15:8]       = r_byte;
                                default: ;
                            endcase
                            if (r_count == CNT_W'(15)) begin
                                n_count = '0;
                                if (r_format_tag != FMT_PCM) begin
                                    emit        = 1'b1;
                                    emit_status = ST_NOT_PCM;
                                end else begin
                                    n_fmt_seen = 1'b1;
                                    if (r_data_seen) begin
                                        emit = 1'b1;
                                    end else begin
                                        n_len   = fmt_rest;
                                        n_phase = (fmt_rest == 32'd0) ? PH_CHUNK_ID : PH_SKIP;
                                    end
                                end
                            end
                        end
                        PH_SKIP: begin
                            n_count = r_count;
                            n_len   = r_len - 32'd1;
                            if (n_len == 32'd0) begin
                                n_count = '0;
                                n_phase = PH_CHUNK_ID;
                            end
                        end
                        PH_DONE: begin
                            n_count = r_count;
                        end
                    endcase
                end
                default: ;
            endcase
            if (emit) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_SIG_RIFF;
            r_count       <= '0;
            r_id          <= '0;
            r_len         <= '0;
            r_fmt_seen    <= 1'b0;
            r_data_seen   <= 1'b0;
            r_format_tag  <= '0;
            r_rate        <= '0;
            r_channels    <= '0;
            r_bits        <= '0;
            r_payload_len <= '0;
        end else begin
            if (load_in) begin
                r_in_valid <= i_in_valid;
            end
            if (can_proc) begin
                r_out_valid <= proc && emit;
            end
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_id          <= n_id;
            r_len         <= n_len;
            r_fmt_seen    <= n_fmt_seen;
            r_data_seen   <= n_data_seen;
            r_format_tag  <= n_format_tag;
            r_rate        <= n_rate;
            r_channels    <= n_channels;
            r_bits        <= n_bits;
            r_payload_len <= n_payload_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_action <= i_action;
            r_byte   <= i_stream_byte;
        end
        if (proc && emit) begin
            r_out_status <= emit_status;
            // error results carry zero fields
            if (emit_status == ST_OK) begin
                r_out_rate     <= n_rate;
                r_out_channels <= n_channels;
                r_out_bits     <= n_bits;
                r_out_size     <= n_payload_len;
            end else begin
                r_out_rate     <= '0;
                r_out_channels <= '0;
                r_out_bits     <= '0;
                r_out_size     <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_rate_hz       = r_out_rate;
    assign o_channel_count = r_out_channels;
    assign o_sample_bits   = r_out_bits;
    assign o_payload_size  = r_out_size;

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_action == ACT_RESTART) |=>
            (r_phase == PH_SIG_RIFF && !r_fmt_seen && !r_data_seen && r_count == '0))
        else $error("restart did not return parser to its initial state");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |->
            (r_out_rate == '0 && r_out_channels == '0 && r_out_bits == '0 &&
             r_out_size == '0))
        else $error("error result carries nonzero fields");

    a_ok_both_chunks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OK && r_phase == PH_DONE) |->
            (r_fmt_seen && r_data_seen))
        else $error("ok result without both fmt and data chunks");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_len != '0))
        else $error("skip phase entered with zero bytes left");

    a_sig_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIG_RIFF || r_phase == PH_RIFF_SIZE || r_phase == PH_SIG_WAVE ||
         r_phase == PH_CHUNK_ID || r_phase == PH_CHUNK_SIZE) |-> (r_count < CNT_W'(4)))
        else $error("byte index out of range in a four-byte phase");

endmodule

// ===== dv/wav_riff_header_parser_tb.sv =====
`timescale 1ns / 100ps

import wrhp_pkg::*;

typedef struct {
    t_status     status;
    logic [31:0] rate;
    logic [15:0] channels;
    logic [15:0] bits;
    logic [31:0] payload_len;
} t_header;

class header_checker;
    t_phase      phase;
    int unsigned pos;
    logic [31:0] id_shift;
    logic [31:0] chunk_len;
    bit          fmt_seen;
    bit          data_seen;
    logic [15:0] tag;
    logic [31:0] rate;
    logic [15:0] channels;
    logic [15:0] bits;
    logic [31:0] payload_len;

    t_header     pending_headers[$];
    int unsigned live_items;
    int unsigned headers_expected;
    int unsigned headers_ok;
    int unsigned headers_checked;
    int unsigned failures;

    function new();
        restart_parse();
    endfunction

    function void restart_parse();
        phase       = PH_SIG_RIFF;
        pos         = 0;
        id_shift    = '0;
        chunk_len   = '0;
        fmt_seen    = 1'b0;
        data_seen   = 1'b0;
        tag         = '0;
        rate        = '0;
        channels    = '0;
        bits        = '0;
        payload_len = '0;
    endfunction

    function void emit_header(t_status st);
        t_header h;
        h.status      = st;
        h.rate        = (st == ST_OK) ? rate : '0;
        h.channels    = (st == ST_OK) ? channels : '0;
        h.bits        = (st == ST_OK) ? bits : '0;
        h.payload_len = (st == ST_OK) ? payload_len : '0;
        pending_headers.push_back(h);
        headers_expected++;
        if (st == ST_OK) headers_ok++;
        phase = PH_DONE;
    endfunction

    function void start_skip(logic [31:0] len);
        chunk_len = len;
        pos       = 0;
        phase     = (len == 0) ? PH_CHUNK_ID : PH_SKIP;
    endfunction

    function void take_byte(logic [7:0] b);
        case (phase)
            PH_SIG_RIFF, PH_SIG_WAVE: begin
                id_shift = {id_shift[23:0], b};
                pos++;
                if (pos >= 4) begin
                    if (id_shift != ((phase == PH_SIG_RIFF) ? ID_RIFF : ID_WAVE)) begin
                        emit_header(ST_BAD_SIG);
                    end else begin
                        pos   = 0;
                        phase = (phase == PH_SIG_RIFF) ? PH_RIFF_SIZE : PH_CHUNK_ID;
                    end
                end
            end
            PH_RIFF_SIZE: begin
                pos++;
                if (pos >= 4) begin
                    pos   = 0;
                    phase = PH_SIG_WAVE;
                end
            end
            PH_CHUNK_ID: begin
                id_shift = {id_shift[23:0], b};
                pos++;
                if (pos >= 4) begin
                    pos       = 0;
                    chunk_len = '0;
                    phase     = PH_CHUNK_SIZE;
                end
            end
            PH_CHUNK_SIZE: begin
                chunk_len |= 32'(b) << (8 * (pos % 4));
                pos++;
                if (pos >= 4) begin
                    pos = 0;
                    if (id_shift == ID_FMT) begin
                        phase = PH_FMT_BODY;
                    end else if (id_shift == ID_DATA) begin
                        payload_len = chunk_len;
                        data_seen   = 1'b1;
                        if (fmt_seen) emit_header(ST_OK);
                        else start_skip(chunk_len);
                    end else begin
                        start_skip(chunk_len);
                    end
                end
            end
            PH_FMT_BODY: begin
                // fields sit little-endian; byte rate and block align are dropped
                if (pos < 2) tag[8*pos +: 8] = b;
                else if (pos < 4) channels[8*(pos-2) +: 8] = b;
                else if (pos < 8) rate[8*(pos-4) +: 8] = b;
                else if (pos >= 14 && pos < 16) bits[8*(pos-14) +: 8] = b;
                pos++;
                if (pos >= FMT_BODY_LEN) begin
                    if (tag != FMT_PCM) begin
                        emit_header(ST_NOT_PCM);
                    end else begin
                        fmt_seen = 1'b1;
                        if (data_seen) emit_header(ST_OK);
                        else start_skip((chunk_len > FMT_BODY_LEN) ?
                                        chunk_len - FMT_BODY_LEN : '0);
                    end
                end
            end
            PH_SKIP: begin
                chunk_len = chunk_len - 1;
                if (chunk_len == 0) begin
                    pos   = 0;
                    phase = PH_CHUNK_ID;
                end
            end
            default: ;
        endcase
    endfunction

    function void note_transfer(t_action act, logic [7:0] b);
        live_items++;
        case (act)
            ACT_RESTART: restart_parse();
            ACT_BYTE:    take_byte(b);
            ACT_END: begin
                if (phase == PH_SIG_RIFF || phase == PH_RIFF_SIZE || phase == PH_SIG_WAVE)
                    emit_header(ST_BAD_SIG);
                else if (phase != PH_DONE)
                    emit_header(ST_MISSING);
            end
            default: ;
        endcase
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            failures++;
        end
    endfunction

    function void check_result(t_header got);
        t_header want;
        if (pending_headers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, got.status);
            failures++;
            return;
        end
        want = pending_headers.pop_front();
        headers_checked++;
        compare("status", want.status, got.status);
        compare("rate", want.rate, got.rate);
        compare("channel_count", want.channels, got.channels);
        compare("sample_bits", want.bits, got.bits);
        compare("payload_size", want.payload_len, got.payload_len);
    endfunction
endclass

module wav_riff_header_parser_tb;

    localparam int unsigned CYCLE_LIMIT = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action = ACT_NONE;
    logic [7:0]  i_stream_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_rate_hz;
    logic [15:0] o_channel_count;
    logic [15:0] o_sample_bits;
    logic [31:0] o_payload_size;

    header_checker sb = new();
    bit            quiet = 1'b0;
    int unsigned   file_budget = 32'hFFFF_FFFF;
    int unsigned   cycle_count = 0;

    wav_riff_header_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_stream_byte   (i_stream_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_rate_hz       (o_rate_hz),
        .o_channel_count (o_channel_count),
        .o_sample_bits   (o_sample_bits),
        .o_payload_size  (o_payload_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     sb.pending_headers.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_header got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_transfer(t_action'(i_action), i_stream_byte);
            if (o_out_valid && !i_out_stall) begin
                got.status      = t_status'(o_status);
                got.rate        = o_rate_hz;
                got.channels    = o_channel_count;
                got.bits        = o_sample_bits;
                got.payload_len = o_payload_size;
                sb.check_result(got);
            end
        end
    end

    // result side: randomly stall the output before each result is taken
    initial begin
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 9);
            if (hold != 0) i_out_stall <= 1'b1;
            do @(negedge i_clk); while (o_out_valid !== 1'b1);
            if (hold != 0) begin
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
                do @(negedge i_clk); while (o_out_valid !== 1'b1);
            end
            @(posedge i_clk);
        end
    end

    task automatic push_transfer(input t_action act, input logic [7:0] b);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_stream_byte <= b;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
    endtask

    task automatic wait_for_headers();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_headers.size() != 0);
        @(posedge i_clk);
    endtask

    // a truncated file drops every byte past its budget
    task automatic file_byte(input logic [7:0] b);
        if (file_budget == 0) return;
        file_budget--;
        push_transfer(ACT_BYTE, b);
    endtask

    task automatic send_id(input logic [31:0] id);
        for (int i = 3; i >= 0; i--) file_byte(id[8*i +: 8]);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) file_byte(w[8*i +: 8]);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_fmt();
        logic [31:0] len;
        logic [15:0] fmt_tag;
        logic [31:0] rate;
        case ($urandom_range(0, 4))
            0:       len = $urandom_range(0, 15);
            1:       len = FMT_BODY_LEN + $urandom_range(1, 6);
            default: len = FMT_BODY_LEN;
        endcase
        fmt_tag = ($urandom_range(0, 6) == 0) ? 16'($urandom) : FMT_PCM;
        rate    = pick_value();
        send_id(ID_FMT);
        send_word(len);
        send_word({16'(pick_value()), fmt_tag});
        send_word(rate);
        send_word($urandom);
        send_word({16'(pick_value()), 16'($urandom)});
        if (len > FMT_BODY_LEN) repeat (len - FMT_BODY_LEN) file_byte(8'($urandom));
    endtask

    // a data chunk seen before fmt gets its payload skipped, so keep it short
    task automatic send_data(input bit with_payload);
        logic [31:0] len;
        len = with_payload ? $urandom_range(0, 8) : pick_value();
        send_id(ID_DATA);
        send_word(len);
        if (with_payload) repeat (len) file_byte(8'($urandom));
    endtask

    task automatic send_other();
        logic [31:0] len;
        len = $urandom_range(0, 6);
        send_id(($urandom_range(0, 1) == 0) ? 32'h4C49_5354 : $urandom);
        send_word(len);
        repeat (len) file_byte(8'($urandom));
    endtask

    task automatic send_wave_file();
        bit fmt_first;
        quiet       = ($urandom_range(0, 4) == 0);
        file_budget = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : 32'hFFFF_FFFF;
        send_id(($urandom_range(0, 15) == 0) ? ID_RIFF ^ (32'd1 << $urandom_range(0, 31))
                                            : ID_RIFF);
        send_word(pick_value());
        send_id(($urandom_range(0, 15) == 0) ? ID_WAVE ^ (32'd1 << $urandom_range(0, 31))
                                            : ID_WAVE);
        repeat ($urandom_range(0, 2)) send_other();
        fmt_first = ($urandom_range(0, 3) != 0);
        if (fmt_first) begin
            send_fmt();
            if ($urandom_range(0, 5) == 0) send_fmt();
            if ($urandom_range(0, 2) == 0) send_other();
            if ($urandom_range(0, 7) != 0) send_data(1'b0);
        end else begin
            send_data(1'b1);
            if ($urandom_range(0, 3) == 0) send_data(1'b1);
            if ($urandom_range(0, 2) == 0) send_other();
            send_fmt();
        end
        if ($urandom_range(0, 5) != 0) push_transfer(ACT_END, 8'($urandom));
        if ($urandom_range(0, 5) == 0) push_transfer(ACT_NONE, 8'($urandom));
        if ($urandom_range(0, 7) == 0) wait_for_headers();
        push_transfer(ACT_RESTART, 8'($urandom));
    endtask

    task automatic send_noise();
        quiet = 1'b0;
        repeat ($urandom_range(4, 40)) begin
            case ($urandom_range(0, 9))
                0:       push_transfer(ACT_END, 8'($urandom));
                1:       push_transfer(ACT_NONE, 8'($urandom));
                2:       push_transfer(ACT_RESTART, 8'($urandom));
                default: push_transfer(ACT_BYTE, 8'($urandom));
            endcase
        end
        push_transfer(ACT_RESTART, 8'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // end of stream at the very start, then bytes after a result
        push_transfer(ACT_RESTART, 8'h00);
        push_transfer(ACT_NONE, 8'hFF);
        push_transfer(ACT_END, 8'h00);
        push_transfer(ACT_BYTE, 8'hFF);
        push_transfer(ACT_RESTART, 8'hFF);
        // bad riff signature
        send_id(32'h5249_4658);
        push_transfer(ACT_RESTART, 8'h00);
        // end of stream while waiting for the wave signature
        send_id(ID_RIFF);
        send_word(32'hFF00_FF00);
        push_transfer(ACT_END, 8'hFF);
        push_transfer(ACT_RESTART, 8'h00);
        wait_for_headers();

        while (sb.live_items < 1650) begin
            if ($urandom_range(0, 9) < 8) send_wave_file();
            else send_noise();
        end

        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_headers.size() != 0);
        repeat (20) @(posedge i_clk);

        $display("%0d transfers sent, %0d results checked (%0d ok, %0d errors)",
                 sb.live_items, sb.headers_checked, sb.headers_ok,
                 sb.headers_expected - sb.headers_ok);
        if (sb.failures == 0 && sb.pending_headers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.failures,
                     sb.pending_headers.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
